// File: rtl/core/scp_pkg.sv
// Shared widths and pipeline word types for the segment crossing point core.
// Used by scp_div_lane and segment_crossing_point_core; no dependencies.
`default_nettype none

package scp_pkg;

  // Coordinate widths, fixed-point degrees with 22 fraction bits.
  localparam int LONG_W  = 31;
  localparam int LAT_W   = 30;

  // Differences of two coordinates.
  localparam int DLONG_W = LONG_W + 1;
  localparam int DLAT_W  = LAT_W + 1;

  // Products of one longitude term and one latitude term, and sums of two.
  localparam int PROD_W  = DLONG_W + DLAT_W;

  // Determinant products are split at SPLIT_W bits into two narrow multiplies.
  localparam int SPLIT_W = 32;
  localparam int PH_W    = PROD_W - SPLIT_W;
  localparam int PL_W    = SPLIT_W + 1;
  localparam int PP_W    = PL_W + DLONG_W;

  // Full numerator of a crossing coordinate.
  localparam int NUM_W   = PROD_W + DLONG_W;

  // Quotient magnitude bits kept by the divider; larger quotients lie outside
  // every segment range.
  localparam int QUO_W   = 32;
  localparam int QS_W    = QUO_W + 1;

  // One divider word: partial remainder, low numerator bits shifting out
  // while quotient bits shift in, divisor magnitude, result sign, overflow.
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  nq;
    logic [PROD_W-1:0] den;
    logic              neg;
    logic              ovf;
  } div_word_t;

  // Sideband that travels beside the divider: the shared window of both
  // segments and whether a crossing point exists at all.
  typedef struct packed {
    logic                     ok;
    logic signed [LONG_W-1:0] xlo;
    logic signed [LONG_W-1:0] xhi;
    logic signed [LAT_W-1:0]  ylo;
    logic signed [LAT_W-1:0]  yhi;
  } side_t;

endpackage

`default_nettype wire

// File: rtl/core/scp_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per register stage.
// Depends on scp_pkg for div_word_t and widths.
`default_nettype none

module scp_div_lane
  import scp_pkg::*;
(
  input  logic      clk,
  input  div_word_t din,
  output div_word_t dout
);

  // Shift in one numerator bit, subtract the divisor if it fits.
  function automatic div_word_t div_step(input div_word_t w);
    div_word_t       r;
    logic [PROD_W:0] t;
    r = w;
    t = {w.rem, w.nq[QUO_W-1]};
    if (t >= {1'b0, w.den}) begin
      t    = t - {1'b0, w.den};
      r.nq = {w.nq[QUO_W-2:0], 1'b1};
    end else begin
      r.nq = {w.nq[QUO_W-2:0], 1'b0};
    end
    r.rem = t[PROD_W-1:0];
    return r;
  endfunction

  div_word_t stg [QUO_W+1];

  assign stg[0] = din;

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    always_ff @(posedge clk) begin
      stg[i+1] <= div_step(stg[i]);
    end
  end

  assign dout = stg[QUO_W];

endmodule

`default_nettype wire

// File: rtl/core/segment_crossing_point_core.sv
// Segment crossing point core: fully pipelined crossing test of two segments.
// Depends on scp_pkg and scp_div_lane (two instances, x and y).
`default_nettype none

// Usage
// -----
// Input channel: a word of eight coordinates (two segments) is taken at every
// rising edge with start high and busy low. busy is high only while rst is
// high, so a new word may be issued in every cycle.
// Output channel: done is high for one cycle with crossed, cross_long and
// cross_lat; the receiver takes the word at the edge that ends that cycle
// and cannot hold it off, so the pipeline never stalls.
// Pipeline: 43 register stages, 11 arithmetic stages plus one stage per
// quotient bit of the 32-bit divider lanes; done travels through the valid
// bits in step with the word.
// Throughput: one word per cycle while rst is low; every stage, including
// each divider bit, is its own register, so words follow back to back.
// Result: crossed is 1 when the carrier lines meet and the point, truncated
// toward zero, lies in both segments' x and y ranges, ends included; the
// point is reported truncated. Parallel, collinear and doubly vertical
// pairs give crossed 0. With crossed 0 both coordinates are zero.
// Reset: synchronous rst drops every word in flight; no done follows it.

module segment_crossing_point_core
  import scp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [LONG_W-1:0] end1_long,
  input  logic signed [LAT_W-1:0]  end1_lat,
  input  logic signed [LONG_W-1:0] end2_long,
  input  logic signed [LAT_W-1:0]  end2_lat,
  input  logic signed [LONG_W-1:0] pt1_long,
  input  logic signed [LAT_W-1:0]  pt1_lat,
  input  logic signed [LONG_W-1:0] pt2_long,
  input  logic signed [LAT_W-1:0]  pt2_lat,
  output logic                     done,
  output logic                     crossed,
  output logic signed [LONG_W-1:0] cross_long,
  output logic signed [LAT_W-1:0]  cross_lat
);

  localparam int LATENCY = 11 + QUO_W;

  logic               acc;
  logic [LATENCY-1:0] vld;

  assign busy = rst;
  assign acc  = start & ~busy;

  // Valid bits travel beside the data; advance every cycle, drop on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], acc};
    end
  end

  assign done = vld[LATENCY-1];

  // ---------------------------------------------------------------- stage 1
  // Capture the input word.
  logic signed [LONG_W-1:0] r1_x1, r1_x2, r1_u1, r1_u2;
  logic signed [LAT_W-1:0]  r1_y1, r1_y2, r1_v1, r1_v2;

  always_ff @(posedge clk) begin
    r1_x1 <= end1_long;
    r1_y1 <= end1_lat;
    r1_x2 <= end2_long;
    r1_y2 <= end2_lat;
    r1_u1 <= pt1_long;
    r1_v1 <= pt1_lat;
    r1_u2 <= pt2_long;
    r1_v2 <= pt2_lat;
  end

  // ---------------------------------------------------------------- stage 2
  // Differences, vertical flags and the window shared by both segments.
  logic signed [DLONG_W-1:0] c2_dx, c2_du, c2_xu;
  logic signed [DLAT_W-1:0]  c2_dy, c2_dv;
  side_t                     c2_side;
  logic signed [LONG_W-1:0]  c2_xmin1, c2_xmax1, c2_xmin2, c2_xmax2;
  logic signed [LAT_W-1:0]   c2_ymin1, c2_ymax1, c2_ymin2, c2_ymax2;

  always_comb begin
    c2_dx = DLONG_W'(r1_x1) - DLONG_W'(r1_x2);
    c2_du = DLONG_W'(r1_u1) - DLONG_W'(r1_u2);
    c2_xu = DLONG_W'(r1_x1) - DLONG_W'(r1_u1);
    c2_dy = DLAT_W'(r1_y1) - DLAT_W'(r1_y2);
    c2_dv = DLAT_W'(r1_v1) - DLAT_W'(r1_v2);
    c2_xmin1 = (r1_x1 < r1_x2) ? r1_x1 : r1_x2;
    c2_xmax1 = (r1_x1 < r1_x2) ? r1_x2 : r1_x1;
    c2_xmin2 = (r1_u1 < r1_u2) ? r1_u1 : r1_u2;
    c2_xmax2 = (r1_u1 < r1_u2) ? r1_u2 : r1_u1;
    c2_ymin1 = (r1_y1 < r1_y2) ? r1_y1 : r1_y2;
    c2_ymax1 = (r1_y1 < r1_y2) ? r1_y2 : r1_y1;
    c2_ymin2 = (r1_v1 < r1_v2) ? r1_v1 : r1_v2;
    c2_ymax2 = (r1_v1 < r1_v2) ? r1_v2 : r1_v1;
    c2_side.xlo = (c2_xmin1 > c2_xmin2) ? c2_xmin1 : c2_xmin2;
    c2_side.xhi = (c2_xmax1 < c2_xmax2) ? c2_xmax1 : c2_xmax2;
    c2_side.ylo = (c2_ymin1 > c2_ymin2) ? c2_ymin1 : c2_ymin2;
    c2_side.yhi = (c2_ymax1 < c2_ymax2) ? c2_ymax1 : c2_ymax2;
    // Two vertical segments never give a point.
    c2_side.ok  = (r1_x1 != r1_x2) || (r1_u1 != r1_u2);
  end

  logic signed [LONG_W-1:0]  r2_x1, r2_x2, r2_u1, r2_u2;
  logic signed [LAT_W-1:0]   r2_y1, r2_y2, r2_v1, r2_v2;
  logic signed [DLONG_W-1:0] r2_dx, r2_du, r2_xu;
  logic signed [DLAT_W-1:0]  r2_dy, r2_dv;
  logic                      r2_vert1, r2_vert2;
  side_t                     r2_side;

  always_ff @(posedge clk) begin
    r2_x1    <= r1_x1;
    r2_y1    <= r1_y1;
    r2_x2    <= r1_x2;
    r2_y2    <= r1_y2;
    r2_u1    <= r1_u1;
    r2_v1    <= r1_v1;
    r2_u2    <= r1_u2;
    r2_v2    <= r1_v2;
    r2_dx    <= c2_dx;
    r2_du    <= c2_du;
    r2_xu    <= c2_xu;
    r2_dy    <= c2_dy;
    r2_dv    <= c2_dv;
    r2_vert1 <= (r1_x1 == r1_x2);
    r2_vert2 <= (r1_u1 == r1_u2);
    r2_side  <= c2_side;
  end

  // ---------------------------------------------------------------- stage 3
  // All first-level products, one multiplier each.
  logic signed [PROD_W-1:0] r3_x1y2, r3_y1x2, r3_u1v2, r3_v1u2;
  logic signed [PROD_W-1:0] r3_dxdv, r3_dydu, r3_v1du, r3_dvxu, r3_y1dx, r3_dyxu;
  logic signed [LONG_W-1:0] r3_x1, r3_u1;
  logic signed [DLONG_W-1:0] r3_dx, r3_du;
  logic signed [DLAT_W-1:0]  r3_dy, r3_dv;
  logic                      r3_vert1, r3_vert2;
  side_t                     r3_side;

  always_ff @(posedge clk) begin
    r3_x1y2  <= r2_x1 * r2_y2;
    r3_y1x2  <= r2_y1 * r2_x2;
    r3_u1v2  <= r2_u1 * r2_v2;
    r3_v1u2  <= r2_v1 * r2_u2;
    r3_dxdv  <= r2_dx * r2_dv;
    r3_dydu  <= r2_dy * r2_du;
    r3_v1du  <= r2_v1 * r2_du;
    r3_dvxu  <= r2_dv * r2_xu;
    r3_y1dx  <= r2_y1 * r2_dx;
    r3_dyxu  <= r2_dy * r2_xu;
    r3_x1    <= r2_x1;
    r3_u1    <= r2_u1;
    r3_dx    <= r2_dx;
    r3_du    <= r2_du;
    r3_dy    <= r2_dy;
    r3_dv    <= r2_dv;
    r3_vert1 <= r2_vert1;
    r3_vert2 <= r2_vert2;
    r3_side  <= r2_side;
  end

  // ---------------------------------------------------------------- stage 4
  // Cross products P, Q, determinant D, and the vertical-case numerators.
  logic signed [PROD_W-1:0]  r4_p, r4_q, r4_d, r4_na, r4_nb;
  logic signed [LONG_W-1:0]  r4_x1, r4_u1;
  logic signed [DLONG_W-1:0] r4_dx, r4_du;
  logic signed [DLAT_W-1:0]  r4_dy, r4_dv;
  logic                      r4_vert1, r4_vert2;
  side_t                     r4_side;

  always_ff @(posedge clk) begin
    r4_p     <= r3_x1y2 - r3_y1x2;
    r4_q     <= r3_u1v2 - r3_v1u2;
    r4_d     <= r3_dxdv - r3_dydu;
    r4_na    <= r3_v1du + r3_dvxu;
    r4_nb    <= r3_y1dx - r3_dyxu;
    r4_x1    <= r3_x1;
    r4_u1    <= r3_u1;
    r4_dx    <= r3_dx;
    r4_du    <= r3_du;
    r4_dy    <= r3_dy;
    r4_dv    <= r3_dv;
    r4_vert1 <= r3_vert1;
    r4_vert2 <= r3_vert2;
    r4_side  <= r3_side;
  end

  // ---------------------------------------------------------------- stage 5
  // Split P and Q into a signed high half and an unsigned low half, then
  // form the eight partial products of P*du, P*dv, Q*dx and Q*dy.
  logic signed [PH_W-1:0] c5_ph, c5_qh;
  logic signed [PL_W-1:0] c5_pl, c5_ql;
  side_t                  c5_side;

  assign c5_ph = r4_p[PROD_W-1:SPLIT_W];
  assign c5_qh = r4_q[PROD_W-1:SPLIT_W];
  assign c5_pl = $signed({1'b0, r4_p[SPLIT_W-1:0]});
  assign c5_ql = $signed({1'b0, r4_q[SPLIT_W-1:0]});

  // Parallel or collinear lines in the general case: no point.
  always_comb begin
    c5_side    = r4_side;
    c5_side.ok = r4_side.ok && (r4_vert1 || r4_vert2 || (r4_d != '0));
  end

  logic signed [PP_W-1:0]   r5_hdu, r5_ldu, r5_hdv, r5_ldv;
  logic signed [PP_W-1:0]   r5_hdx, r5_ldx, r5_hdy, r5_ldy;
  logic signed [PROD_W-1:0] r5_d, r5_na, r5_nb;
  logic signed [LONG_W-1:0] r5_x1, r5_u1;
  logic signed [DLONG_W-1:0] r5_dx, r5_du;
  logic                      r5_vert1, r5_vert2;
  side_t                     r5_side;

  always_ff @(posedge clk) begin
    r5_hdu   <= c5_ph * r4_du;
    r5_ldu   <= c5_pl * r4_du;
    r5_hdv   <= c5_ph * r4_dv;
    r5_ldv   <= c5_pl * r4_dv;
    r5_hdx   <= c5_qh * r4_dx;
    r5_ldx   <= c5_ql * r4_dx;
    r5_hdy   <= c5_qh * r4_dy;
    r5_ldy   <= c5_ql * r4_dy;
    r5_d     <= r4_d;
    r5_na    <= r4_na;
    r5_nb    <= r4_nb;
    r5_x1    <= r4_x1;
    r5_u1    <= r4_u1;
    r5_dx    <= r4_dx;
    r5_du    <= r4_du;
    r5_vert1 <= r4_vert1;
    r5_vert2 <= r4_vert2;
    r5_side  <= c5_side;
  end

  // ---------------------------------------------------------------- stage 6
  // Reassemble the four wide products.
  logic signed [NUM_W-1:0] c6_hdu, c6_ldu, c6_hdv, c6_ldv;
  logic signed [NUM_W-1:0] c6_hdx, c6_ldx, c6_hdy, c6_ldy;

  assign c6_hdu = NUM_W'(r5_hdu);
  assign c6_ldu = NUM_W'(r5_ldu);
  assign c6_hdv = NUM_W'(r5_hdv);
  assign c6_ldv = NUM_W'(r5_ldv);
  assign c6_hdx = NUM_W'(r5_hdx);
  assign c6_ldx = NUM_W'(r5_ldx);
  assign c6_hdy = NUM_W'(r5_hdy);
  assign c6_ldy = NUM_W'(r5_ldy);

  logic signed [NUM_W-1:0]  r6_pdu, r6_pdv, r6_qdx, r6_qdy;
  logic signed [PROD_W-1:0] r6_d, r6_na, r6_nb;
  logic signed [LONG_W-1:0] r6_x1, r6_u1;
  logic signed [DLONG_W-1:0] r6_dx, r6_du;
  logic                      r6_vert1, r6_vert2;
  side_t                     r6_side;

  always_ff @(posedge clk) begin
    r6_pdu   <= (c6_hdu <<< SPLIT_W) + c6_ldu;
    r6_pdv   <= (c6_hdv <<< SPLIT_W) + c6_ldv;
    r6_qdx   <= (c6_hdx <<< SPLIT_W) + c6_ldx;
    r6_qdy   <= (c6_hdy <<< SPLIT_W) + c6_ldy;
    r6_d     <= r5_d;
    r6_na    <= r5_na;
    r6_nb    <= r5_nb;
    r6_x1    <= r5_x1;
    r6_u1    <= r5_u1;
    r6_dx    <= r5_dx;
    r6_du    <= r5_du;
    r6_vert1 <= r5_vert1;
    r6_vert2 <= r5_vert2;
    r6_side  <= r5_side;
  end

  // ---------------------------------------------------------------- stage 7
  // Pick numerator and divisor per lane. A vertical segment fixes x
  // directly, so the x lane divides that coordinate by one.
  logic signed [NUM_W-1:0]  c7_num_x, c7_num_y;
  logic signed [PROD_W-1:0] c7_den_x, c7_den_y;

  always_comb begin
    if (r6_vert1) begin
      c7_num_x = NUM_W'(r6_x1);
      c7_den_x = PROD_W'(1);
      c7_num_y = NUM_W'(r6_na);
      c7_den_y = PROD_W'(r6_du);
    end else if (r6_vert2) begin
      c7_num_x = NUM_W'(r6_u1);
      c7_den_x = PROD_W'(1);
      c7_num_y = NUM_W'(r6_nb);
      c7_den_y = PROD_W'(r6_dx);
    end else begin
      c7_num_x = r6_pdu - r6_qdx;
      c7_den_x = r6_d;
      c7_num_y = r6_pdv - r6_qdy;
      c7_den_y = r6_d;
    end
  end

  logic signed [NUM_W-1:0]  r7_num_x, r7_num_y;
  logic signed [PROD_W-1:0] r7_den_x, r7_den_y;
  side_t                    r7_side;

  always_ff @(posedge clk) begin
    r7_num_x <= c7_num_x;
    r7_num_y <= c7_num_y;
    r7_den_x <= c7_den_x;
    r7_den_y <= c7_den_y;
    r7_side  <= r6_side;
  end

  // ---------------------------------------------------------------- stage 8
  // Magnitudes and the quotient sign (truncation toward zero).
  logic [NUM_W-1:0]  r8_nmag_x, r8_nmag_y;
  logic [PROD_W-1:0] r8_dmag_x, r8_dmag_y;
  logic              r8_neg_x, r8_neg_y;
  side_t             r8_side;

  always_ff @(posedge clk) begin
    r8_nmag_x <= r7_num_x[NUM_W-1] ? -r7_num_x : r7_num_x;
    r8_nmag_y <= r7_num_y[NUM_W-1] ? -r7_num_y : r7_num_y;
    r8_dmag_x <= r7_den_x[PROD_W-1] ? -r7_den_x : r7_den_x;
    r8_dmag_y <= r7_den_y[PROD_W-1] ? -r7_den_y : r7_den_y;
    r8_neg_x  <= r7_num_x[NUM_W-1] ^ r7_den_x[PROD_W-1];
    r8_neg_y  <= r7_num_y[NUM_W-1] ^ r7_den_y[PROD_W-1];
    r8_side   <= r7_side;
  end

  // ---------------------------------------------------------------- stage 9
  // Load the divider words. A quotient that needs more than QUO_W bits is
  // flagged here and the lane result is dropped at the end.
  div_word_t r9_wx, r9_wy;
  side_t     r9_side;

  always_ff @(posedge clk) begin
    r9_wx.rem <= r8_nmag_x[NUM_W-1:QUO_W];
    r9_wx.nq  <= r8_nmag_x[QUO_W-1:0];
    r9_wx.den <= r8_dmag_x;
    r9_wx.neg <= r8_neg_x;
    r9_wx.ovf <= (r8_nmag_x[NUM_W-1:QUO_W] >= r8_dmag_x);
    r9_wy.rem <= r8_nmag_y[NUM_W-1:QUO_W];
    r9_wy.nq  <= r8_nmag_y[QUO_W-1:0];
    r9_wy.den <= r8_dmag_y;
    r9_wy.neg <= r8_neg_y;
    r9_wy.ovf <= (r8_nmag_y[NUM_W-1:QUO_W] >= r8_dmag_y);
    r9_side   <= r8_side;
  end

  // ------------------------------------------------------- divider lanes
  div_word_t d_wx, d_wy;

  scp_div_lane u_div_x (
    .clk  (clk),
    .din  (r9_wx),
    .dout (d_wx)
  );

  scp_div_lane u_div_y (
    .clk  (clk),
    .din  (r9_wy),
    .dout (d_wy)
  );

  // Hold the sideband in step with the divider lanes.
  side_t side_dly [QUO_W+1];

  assign side_dly[0] = r9_side;

  for (genvar i = 0; i < QUO_W; i++) begin : g_side
    always_ff @(posedge clk) begin
      side_dly[i+1] <= side_dly[i];
    end
  end

  // ------------------------------------------------------------ sign stage
  logic signed [QS_W-1:0] c_qx, c_qy;

  assign c_qx = $signed({1'b0, d_wx.nq});
  assign c_qy = $signed({1'b0, d_wy.nq});

  logic signed [QS_W-1:0] rs_qx, rs_qy;
  logic                   rs_ok;
  side_t                  rs_side;

  always_ff @(posedge clk) begin
    rs_qx   <= d_wx.neg ? -c_qx : c_qx;
    rs_qy   <= d_wy.neg ? -c_qy : c_qy;
    rs_ok   <= side_dly[QUO_W].ok && !d_wx.ovf && !d_wy.ovf;
    rs_side <= side_dly[QUO_W];
  end

  // ---------------------------------------------------------- output stage
  // Accept the point only inside the window of both segments.
  logic c_in;

  assign c_in = rs_ok
             && (rs_qx >= QS_W'(rs_side.xlo)) && (rs_qx <= QS_W'(rs_side.xhi))
             && (rs_qy >= QS_W'(rs_side.ylo)) && (rs_qy <= QS_W'(rs_side.yhi));

  always_ff @(posedge clk) begin
    if (rst) begin
      crossed <= 1'b0;
    end else begin
      crossed <= vld[LATENCY-2] & c_in;
    end
  end

  always_ff @(posedge clk) begin
    cross_long <= c_in ? rs_qx[LONG_W-1:0] : '0;
    cross_lat  <= c_in ? rs_qy[LAT_W-1:0] : '0;
  end

  // ------------------------------------------------------------ assertions
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word did not complete after the pipeline latency");

  a_zero_point : assert property (@(posedge clk) disable iff (rst)
    (done && !crossed) |-> (cross_long == '0 && cross_lat == '0))
    else $error("point fields nonzero without a crossing");

  a_crossed_done : assert property (@(posedge clk) disable iff (rst)
    crossed |-> done)
    else $error("crossed raised outside a result cycle");

endmodule

`default_nettype wire
